// File: design/meter_telegram_deframer_unit_defines.svh
// Assertion macros used by the meter telegram deframer engine RTL
`ifndef METER_TELEGRAM_DEFRAMER_UNIT_DEFINES_SVH
`define METER_TELEGRAM_DEFRAMER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MTD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtd assertion failed");
// next-cycle implication
`define MTD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtd assertion failed");
`else
`define MTD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MTD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: design/mtd_pkg.sv
// Types and constants of the meter telegram deframer
`timescale 1ns / 1ps
package mtd_pkg;

   localparam int WIN_DEPTH = 7;
   localparam int QUEUE_DEPTH = 4;               // power of two, pointers wrap
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   localparam logic [15:0] DEFAULT_TIMEOUT = 16'd200;
   localparam logic [15:0] RESET_MAX_LEN = 16'd1024;
   localparam logic [16:0] SIZE_MARGIN = 17'd8;

   localparam logic [1:0] REG_MAX_LEN = 2'd0;
   localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd1;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [2:0] PH_SEEK = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_EMPTY = 3'd2;
   localparam logic [2:0] PH_BODY = 3'd3;
   localparam logic [2:0] PH_IGNORE = 3'd4;

   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_SEP = 3'd1;
   localparam logic [2:0] KIND_BODY = 3'd2;
   localparam logic [2:0] KIND_CRC = 3'd3;
   localparam logic [2:0] KIND_STATUS = 3'd4;

   localparam logic [2:0] STAT_OK = 3'd0;
   localparam logic [2:0] STAT_LARGE = 3'd1;
   localparam logic [2:0] STAT_INCOMPLETE = 3'd2;
   localparam logic [2:0] STAT_NOHEADER = 3'd3;
   localparam logic [2:0] STAT_OVERFLOW = 3'd4;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_BANG = 8'h21;

   typedef struct packed {
      logic       flush;
      logic       ovf;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [2:0]  status;
      logic [15:0] body_length;
      logic        last_of_run;
   } rsp_type;

endpackage

// File: design/mtd_front.sv
// Front end: accepts bytes and ticks, tracks burst length and silence, issues commands
`timescale 1ns / 1ps
module mtd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_func,
   input  logic [7:0]       req_byte_value,
   input  logic [15:0]      max_len,
   input  logic [15:0]      idle_timeout,
   input  logic             cmd_full,
   output logic             cmd_push,
   output mtd_pkg::cmd_type cmd
);

   logic [16:0] burst_ff, burst_in;
   logic [15:0] idle_ff, idle_in;
   logic        accept;
   logic        overflow;
   logic [15:0] idle_step;
   logic [15:0] limit;

   assign req_full = cmd_full;
   assign accept = req_push && !cmd_full;
   assign overflow = burst_ff > {1'b0, max_len};
   assign idle_step = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign limit = (idle_timeout == 16'd0) ? mtd_pkg::DEFAULT_TIMEOUT : idle_timeout;

   always_comb begin
      burst_in = burst_ff;
      idle_in = idle_ff;
      cmd_push = 1'b0;
      cmd.flush = 1'b0;
      cmd.ovf = 1'b0;
      cmd.data = req_byte_value;
      if (accept) begin
         if (req_func == mtd_pkg::FUNC_BYTE) begin
            cmd_push = 1'b1;
            cmd.ovf = overflow;
            burst_in = (overflow ? 17'd0 : burst_ff) + 17'd1;
            idle_in = 16'd0;
         end else if (burst_ff != 17'd0) begin
            if (idle_step > limit) begin
               cmd_push = 1'b1;
               cmd.flush = 1'b1;
               burst_in = 17'd0;
               idle_in = 16'd0;
            end else begin
               idle_in = idle_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff <= 17'd0;
         idle_ff <= 16'd0;
      end else begin
         burst_ff <= burst_in;
         idle_ff <= idle_in;
      end
   end

endmodule

// File: design/mtd_cmd_queue.sv
// Short command queue between front end and engine
`timescale 1ns / 1ps
module mtd_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mtd_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output mtd_pkg::cmd_type head,
   output logic             empty
);

   logic [mtd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mtd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mtd_pkg::QCNT_W-1:0] count_ff, count_in;
   mtd_pkg::cmd_type           entry_ff [mtd_pkg::QUEUE_DEPTH];
   logic                       do_push;
   logic                       do_pop;

   assign full = count_ff == mtd_pkg::QCNT_W'(mtd_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/mtd_engine.sv
// Back end: lookahead window, telegram phase tracking and result generation
`timescale 1ns / 1ps
`include "meter_telegram_deframer_unit_defines.svh"
module mtd_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      max_len,
   input  mtd_pkg::cmd_type cmd,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output mtd_pkg::rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_JUDGE = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   localparam logic [2:0] ACT_LARGE = 3'd0;
   localparam logic [2:0] ACT_SKIP = 3'd1;
   localparam logic [2:0] ACT_LINE1 = 3'd2;
   localparam logic [2:0] ACT_LINE2 = 3'd3;
   localparam logic [2:0] ACT_FOOTER = 3'd4;
   localparam logic [2:0] ACT_BLARGE = 3'd5;
   localparam logic [2:0] ACT_BODY = 3'd6;
   localparam logic [2:0] ACT_DROP = 3'd7;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  win_ff [mtd_pkg::WIN_DEPTH];
   logic [7:0]  win_in [mtd_pkg::WIN_DEPTH];
   logic [2:0]  wc_ff, wc_in;
   logic [15:0] tc_ff, tc_in;
   logic [15:0] bc_ff, bc_in;
   logic [2:0]  step_ff, step_in;
   logic        flush_mode_ff, flush_mode_in;

   logic             seek;
   logic             cr_pair;
   logic             footer;
   logic             tele_large;
   logic             body_large;
   logic             line_phase;
   logic [2:0]       line_kind;
   logic [2:0]       line_base_phase;
   logic [15:0]      line_tc_base;
   logic [2:0]       act;
   logic [2:0]       n_res;
   logic             apply;
   logic             final_status;
   mtd_pkg::rsp_type j_rsp;

   assign seek = phase_ff == mtd_pkg::PH_SEEK;
   assign tele_large = ({1'b0, tc_ff} + mtd_pkg::SIZE_MARGIN) >= {1'b0, max_len};
   assign body_large = bc_ff >= max_len;
   assign cr_pair = (win_ff[0] == mtd_pkg::CH_CR) && (wc_ff >= 3'd2);
   assign footer = (phase_ff == mtd_pkg::PH_BODY) && (win_ff[0] == mtd_pkg::CH_BANG)
                   && (wc_ff == 3'(mtd_pkg::WIN_DEPTH)) && (win_ff[5] == mtd_pkg::CH_CR)
                   && (win_ff[6] == mtd_pkg::CH_LF);
   assign line_phase = (seek && win_ff[0] == mtd_pkg::CH_SLASH)
                       || phase_ff == mtd_pkg::PH_HEADER || phase_ff == mtd_pkg::PH_EMPTY;
   assign line_kind = (phase_ff == mtd_pkg::PH_EMPTY) ? mtd_pkg::KIND_SEP
                                                       : mtd_pkg::KIND_HEADER;
   assign line_base_phase = seek ? mtd_pkg::PH_HEADER : phase_ff;
   assign line_tc_base = seek ? 16'd0 : tc_ff;
   assign final_status = phase_ff != mtd_pkg::PH_IGNORE;

   // classify the front byte of the window
   always_comb begin
      if (tele_large) begin
         act = ACT_LARGE;
      end else if (seek && win_ff[0] != mtd_pkg::CH_SLASH) begin
         act = ACT_SKIP;
      end else if (line_phase) begin
         act = cr_pair ? ACT_LINE2 : ACT_LINE1;
      end else if (phase_ff == mtd_pkg::PH_BODY) begin
         if (footer) begin
            act = ACT_FOOTER;
         end else if (body_large) begin
            act = ACT_BLARGE;
         end else begin
            act = ACT_BODY;
         end
      end else begin
         act = ACT_DROP;
      end
   end

   always_comb begin
      j_rsp = '0;
      unique case (act)
         ACT_LARGE, ACT_BLARGE: begin
            n_res = 3'd1;
            j_rsp.kind = mtd_pkg::KIND_STATUS;
            j_rsp.status = mtd_pkg::STAT_LARGE;
            j_rsp.body_length = bc_ff;
         end
         ACT_SKIP, ACT_DROP: begin
            n_res = 3'd0;
         end
         ACT_LINE1, ACT_LINE2: begin
            n_res = (act == ACT_LINE2) ? 3'd2 : 3'd1;
            j_rsp.kind = line_kind;
            j_rsp.data_byte = (step_ff == 3'd0) ? win_ff[0] : win_ff[1];
         end
         ACT_FOOTER: begin
            n_res = 3'd5;
            if (step_ff == 3'd4) begin
               j_rsp.kind = mtd_pkg::KIND_STATUS;
               j_rsp.status = mtd_pkg::STAT_OK;
               j_rsp.body_length = bc_ff;
            end else begin
               j_rsp.kind = mtd_pkg::KIND_CRC;
               j_rsp.data_byte = win_ff[step_ff + 3'd1];
            end
         end
         ACT_BODY: begin
            n_res = 3'd1;
            j_rsp.kind = mtd_pkg::KIND_BODY;
            j_rsp.data_byte = win_ff[0];
         end
      endcase
      // in a flush only a status result can end the transaction run
      j_rsp.last_of_run = (step_ff == n_res - 3'd1)
                          && (!flush_mode_ff || j_rsp.kind == mtd_pkg::KIND_STATUS);
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      win_in = win_ff;
      wc_in = wc_ff;
      tc_in = tc_ff;
      bc_in = bc_ff;
      step_in = step_ff;
      flush_mode_in = flush_mode_ff;
      cmd_pop = 1'b0;
      rsp_push = 1'b0;
      rsp_data = '0;
      apply = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               if (cmd.flush) begin
                  cmd_pop = 1'b1;
                  flush_mode_in = 1'b1;
                  if (wc_ff != 3'd0 && phase_ff != mtd_pkg::PH_IGNORE) begin
                     state_in = ST_JUDGE;
                  end else begin
                     state_in = ST_FINAL;
                  end
               end else if (cmd.ovf) begin
                  if (!rsp_full) begin
                     rsp_push = 1'b1;
                     rsp_data.kind = mtd_pkg::KIND_STATUS;
                     rsp_data.status = mtd_pkg::STAT_OVERFLOW;
                     rsp_data.body_length = bc_ff;
                     rsp_data.last_of_run = 1'b1;
                     cmd_pop = 1'b1;
                     phase_in = mtd_pkg::PH_SEEK;
                     tc_in = 16'd0;
                     bc_in = 16'd0;
                     win_in[0] = cmd.data;
                     wc_in = 3'd1;
                  end
               end else begin
                  cmd_pop = 1'b1;
                  flush_mode_in = 1'b0;
                  if (phase_ff != mtd_pkg::PH_IGNORE) begin
                     win_in[wc_ff] = cmd.data;
                     wc_in = wc_ff + 3'd1;
                     if (wc_ff == 3'(mtd_pkg::WIN_DEPTH - 1)) begin
                        state_in = ST_JUDGE;
                     end
                  end
               end
            end
         end
         ST_JUDGE: begin
            if (n_res != 3'd0) begin
               if (!rsp_full) begin
                  rsp_push = 1'b1;
                  rsp_data = j_rsp;
                  if (step_ff == n_res - 3'd1) begin
                     apply = 1'b1;
                  end else begin
                     step_in = step_ff + 3'd1;
                  end
               end
            end else begin
               apply = 1'b1;
            end
            if (apply) begin
               step_in = 3'd0;
               case (act) inside
                  ACT_LARGE, ACT_BLARGE, ACT_FOOTER: begin
                     phase_in = mtd_pkg::PH_IGNORE;
                     wc_in = 3'd0;
                  end
                  ACT_DROP: begin
                     wc_in = 3'd0;
                  end
                  ACT_LINE2: begin
                     for (int i = 0; i < mtd_pkg::WIN_DEPTH - 2; i++) begin
                        win_in[i] = win_ff[i + 2];
                     end
                     win_in[mtd_pkg::WIN_DEPTH - 2] = 8'd0;
                     win_in[mtd_pkg::WIN_DEPTH - 1] = 8'd0;
                     wc_in = wc_ff - 3'd2;
                     tc_in = line_tc_base + 16'd2;
                     bc_in = seek ? 16'd0 : bc_ff;
                     if (win_ff[1] == mtd_pkg::CH_LF) begin
                        phase_in = (line_base_phase == mtd_pkg::PH_HEADER)
                                   ? mtd_pkg::PH_EMPTY : mtd_pkg::PH_BODY;
                     end else begin
                        phase_in = line_base_phase;
                     end
                  end
                  default: begin
                     for (int i = 0; i < mtd_pkg::WIN_DEPTH - 1; i++) begin
                        win_in[i] = win_ff[i + 1];
                     end
                     win_in[mtd_pkg::WIN_DEPTH - 1] = 8'd0;
                     wc_in = wc_ff - 3'd1;
                     if (act == ACT_LINE1) begin
                        tc_in = line_tc_base + 16'd1;
                        bc_in = seek ? 16'd0 : bc_ff;
                        phase_in = line_base_phase;
                     end else if (act == ACT_BODY) begin
                        tc_in = tc_ff + 16'd1;
                        bc_in = bc_ff + 16'd1;
                     end
                  end
               endcase
               if (!flush_mode_ff) begin
                  state_in = ST_IDLE;
               end else if (wc_in != 3'd0 && phase_in != mtd_pkg::PH_IGNORE) begin
                  state_in = ST_JUDGE;
               end else begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            if (!final_status || !rsp_full) begin
               if (final_status) begin
                  rsp_push = 1'b1;
                  rsp_data.kind = mtd_pkg::KIND_STATUS;
                  rsp_data.status = seek ? mtd_pkg::STAT_NOHEADER
                                         : mtd_pkg::STAT_INCOMPLETE;
                  rsp_data.body_length = bc_ff;
                  rsp_data.last_of_run = 1'b1;
               end
               phase_in = mtd_pkg::PH_SEEK;
               wc_in = 3'd0;
               tc_in = 16'd0;
               bc_in = 16'd0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= mtd_pkg::PH_SEEK;
         wc_ff <= 3'd0;
         tc_ff <= 16'd0;
         bc_ff <= 16'd0;
         step_ff <= 3'd0;
         flush_mode_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         wc_ff <= wc_in;
         tc_ff <= tc_in;
         bc_ff <= bc_in;
         step_ff <= step_in;
         flush_mode_ff <= flush_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   `MTD_ASSERT_IMP(a_judge_has_bytes, clock, reset, state_ff == ST_JUDGE, wc_ff != 3'd0)
   `MTD_ASSERT_IMP(a_ignore_no_window, clock, reset, phase_ff == mtd_pkg::PH_IGNORE, wc_ff == 3'd0)
   `MTD_ASSERT_NXT(a_overflow_restart, clock, reset, cmd_pop && !cmd.flush && cmd.ovf, (phase_ff == mtd_pkg::PH_SEEK) && (wc_ff == 3'd1))
   `MTD_ASSERT_IMP(a_push_has_room, clock, reset, rsp_push, !rsp_full)

endmodule

// File: design/mtd_rsp_queue.sv
// Result queue feeding the output ports
`timescale 1ns / 1ps
module mtd_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mtd_pkg::rsp_type push_data,
   output logic             full,
   input  logic             pop,
   output mtd_pkg::rsp_type head,
   output logic             empty
);

   logic [mtd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mtd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mtd_pkg::QCNT_W-1:0] count_ff, count_in;
   mtd_pkg::rsp_type           entry_ff [mtd_pkg::QUEUE_DEPTH];
   logic                       do_push;
   logic                       do_pop;

   assign full = count_ff == mtd_pkg::QCNT_W'(mtd_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/meter_telegram_deframer_unit.sv
// Top level of the meter telegram deframer: config registers, front end, queues, engine
// Path: a judged byte's first result passes the command queue entry, the engine window
// and judge state, then the result queue entry. Throughput: one input per cycle into a
// 4-deep command queue while it is not full; the engine takes no new byte while judging,
// a full result queue stalls it; a burst-end flush judges the bytes left in the window.
// Reset: synchronous; clears queues, window count and counters, limit 1024, timeout 200.
`timescale 1ns / 1ps
module meter_telegram_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_body_length,
   output logic        rsp_last_of_run,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0]      max_len_ff, max_len_in;
   logic [15:0]      timeout_ff, timeout_in;
   logic             cmd_push;
   mtd_pkg::cmd_type cmd_in_data;
   logic             cmd_full;
   logic             cmd_pop;
   mtd_pkg::cmd_type cmd_head;
   logic             cmd_empty;
   logic             rsp_push;
   mtd_pkg::rsp_type rsp_in_data;
   logic             rsp_full;
   mtd_pkg::rsp_type rsp_head;

   always_comb begin
      max_len_in = max_len_ff;
      timeout_in = timeout_ff;
      if (csr_wen) begin
         if (csr_index == mtd_pkg::REG_MAX_LEN) begin
            max_len_in = csr_wdata;
         end else if (csr_index == mtd_pkg::REG_IDLE_TIMEOUT) begin
            timeout_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= mtd_pkg::RESET_MAX_LEN;
         timeout_ff <= mtd_pkg::DEFAULT_TIMEOUT;
      end else begin
         max_len_ff <= max_len_in;
         timeout_ff <= timeout_in;
      end
   end

   mtd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_byte_value (req_byte_value),
      .max_len        (max_len_ff),
      .idle_timeout   (timeout_ff),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd            (cmd_in_data)
   );

   mtd_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty)
   );

   mtd_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .max_len   (max_len_ff),
      .cmd       (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in_data)
   );

   mtd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .head      (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_kind = rsp_head.kind;
   assign rsp_data_byte = rsp_head.data_byte;
   assign rsp_status = rsp_head.status;
   assign rsp_body_length = rsp_head.body_length;
   assign rsp_last_of_run = rsp_head.last_of_run;

endmodule
